>>> rtl/core/sliding_window_latency_stats_top_macros.svh
// Assertion macros for the RTL top level.
`ifndef SLIDING_WINDOW_LATENCY_STATS_TOP_MACROS_SVH
`define SLIDING_WINDOW_LATENCY_STATS_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SWLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define SWLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SWLS_ASSERT_NOW(label, clk, rst, ante, cons)
`define SWLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/swls_pkg.sv
package swls_pkg;

   localparam int WINDOW = 16;
   localparam int DATA_W = 24;
   localparam int HELD_W = 5;
   localparam int AW     = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam int CW     = $clog2(WINDOW + 1);
   localparam int SUMW   = DATA_W + AW;
   localparam int VAR_W  = 2 * DATA_W;
   localparam int SQW    = VAR_W + AW;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [HELD_W-1:0] held_type;
   typedef logic [AW-1:0]     addr_type;
   typedef logic [CW-1:0]     cnt_type;
   typedef logic [SUMW-1:0]   sum_type;
   typedef logic [VAR_W-1:0]  var_type;
   typedef logic [SQW-1:0]    sq_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV_MEAN,
      ST_DEV,
      ST_DIV_VAR,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/swls_if.sv
interface swls_req_if;
   logic               valid;
   logic               ready;
   swls_pkg::data_type latency_us;

   modport source (output valid, output latency_us, input ready);
   modport sink   (input valid, input latency_us, output ready);
endinterface

interface swls_rsp_if;
   logic               valid;
   logic               ready;
   swls_pkg::data_type mean_us;
   swls_pkg::data_type stdev_us;
   swls_pkg::held_type held_count;
   logic               window_full;

   modport source (output valid, output mean_us, output stdev_us, output held_count,
                   output window_full, input ready);
   modport sink   (input valid, input mean_us, input stdev_us, input held_count,
                   input window_full, output ready);
endinterface

>>> rtl/core/swls_ring.sv
module swls_ring (
   input  logic               clock,
   input  logic               wr_en,
   input  swls_pkg::addr_type wr_addr,
   input  swls_pkg::data_type wr_data,
   input  swls_pkg::addr_type rd_addr,
   output swls_pkg::data_type rd_data
);

   swls_pkg::data_type mem [swls_pkg::WINDOW];
   swls_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/swls_div.sv
// Restoring divider, one quotient bit per cycle.
module swls_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  swls_pkg::sq_type  dividend,
   input  swls_pkg::cnt_type divisor,
   output logic              busy,
   output logic              done,
   output swls_pkg::sq_type  quotient
);

   localparam int STEP_W = $clog2(swls_pkg::SQW + 1);

   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   swls_pkg::sq_type   quo_ff, quo_in;
   swls_pkg::cnt_type  rem_ff, rem_in;
   logic [swls_pkg::CW:0] trial;
   logic               ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[swls_pkg::SQW-1]};
      ge      = trial >= {1'b0, divisor};
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(swls_pkg::SQW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[swls_pkg::SQW-2:0], ge};
         rem_in  = ge ? swls_pkg::cnt_type'(trial - {1'b0, divisor})
                      : swls_pkg::cnt_type'(trial);
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/swls_isqrt.sv
// Bitwise restoring integer square root, one result bit per cycle.
module swls_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  swls_pkg::var_type  value,
   output logic               done,
   output swls_pkg::data_type root
);

   swls_pkg::var_type        v_ff, v_in;
   swls_pkg::var_type        root_ff, root_in;
   swls_pkg::var_type        bit_ff, bit_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [swls_pkg::VAR_W:0] trial;
   logic                     ge;

   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      ge      = {1'b0, v_ff} >= trial;
      v_in    = v_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = value;
         root_in = '0;
         bit_in  = swls_pkg::var_type'(1) << (swls_pkg::VAR_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            v_in    = swls_pkg::var_type'({1'b0, v_ff} - trial);
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff[swls_pkg::DATA_W-1:0];

endmodule

>>> rtl/core/sliding_window_latency_stats_top.sv
// Sliding-window latency statistics.
// req_ch carries one latency sample (microseconds) per beat; rsp_ch returns one
// beat per sample with the floor mean, floor population standard deviation,
// the number of samples held and a window-full flag. Samples live in a 16-entry
// ring memory; once full, the oldest entry is overwritten.
// Each sample is processed on its own: a read pass over the held entries forms
// the sum, a bit-serial divider yields the mean, a second read pass with one
// multiplier accumulates squared deviations, the same divider yields the
// variance and a bit-serial root unit gives the deviation.
// The two 52-step divisions and the 24-step root dominate the work on a sample.
// A new sample is taken once the previous one has left the datapath, so the
// block does not take a sample while the one before it is still in work.
// The result sits in an output register: while rsp_ch is stalled the next
// sample is still accepted and worked on, and only its final load waits.
// Reset (synchronous) empties the window and drops any pending result; ring
// contents are not cleared, as only written entries are ever read.
`include "sliding_window_latency_stats_top_macros.svh"

module sliding_window_latency_stats_top (
   input logic        clock,
   input logic        reset,
   swls_req_if.sink   req_ch,
   swls_rsp_if.source rsp_ch
);

   swls_pkg::state_type state_ff, state_in;

   swls_pkg::addr_type slot_ff, slot_in;
   swls_pkg::cnt_type  count_ff, count_in;
   swls_pkg::cnt_type  rd_cnt_ff, rd_cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               prod_vld_ff, prod_vld_in;
   swls_pkg::sum_type  sum_ff, sum_in;
   swls_pkg::sq_type   sq_ff, sq_in;
   swls_pkg::data_type mean_ff, mean_in;
   swls_pkg::var_type  prod_ff, prod_in;

   logic               out_vld_ff, out_vld_in;
   swls_pkg::data_type out_mean_ff, out_mean_in;
   swls_pkg::data_type out_stdev_ff, out_stdev_in;
   swls_pkg::held_type out_held_ff, out_held_in;
   logic               out_full_ff, out_full_in;

   logic               req_fire, rsp_fire, out_free;
   logic               issue, pass_done;
   logic               div_start, div_busy, div_done;
   logic               sqrt_start, sqrt_done, load_out;
   swls_pkg::sq_type   div_dividend, div_quotient;
   swls_pkg::data_type rd_data, stdev;
   swls_pkg::data_type dev_abs;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign out_free  = !out_vld_ff || rsp_ch.ready;
   assign pass_done = (rd_cnt_ff == count_ff) && !rd_vld_ff && !prod_vld_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swls_pkg::ST_IDLE:     if (req_fire)  state_in = swls_pkg::ST_SUM;
         swls_pkg::ST_SUM:      if (pass_done) state_in = swls_pkg::ST_DIV_MEAN;
         swls_pkg::ST_DIV_MEAN: if (div_done)  state_in = swls_pkg::ST_DEV;
         swls_pkg::ST_DEV:      if (pass_done) state_in = swls_pkg::ST_DIV_VAR;
         swls_pkg::ST_DIV_VAR:  if (div_done)  state_in = swls_pkg::ST_SQRT;
         swls_pkg::ST_SQRT:     if (sqrt_done) state_in = swls_pkg::ST_DONE;
         swls_pkg::ST_DONE:     if (out_free)  state_in = swls_pkg::ST_IDLE;
         default:                              state_in = swls_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs.
   always_comb begin
      req_ch.ready = 1'b0;
      issue        = 1'b0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         swls_pkg::ST_IDLE:     req_ch.ready = 1'b1;
         swls_pkg::ST_SUM: begin
            issue     = rd_cnt_ff != count_ff;
            div_start = pass_done;
         end
         swls_pkg::ST_DEV: begin
            issue     = rd_cnt_ff != count_ff;
            div_start = pass_done;
         end
         swls_pkg::ST_DIV_VAR:  sqrt_start = div_done;
         swls_pkg::ST_DONE:     load_out   = out_free;
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      slot_in     = slot_ff;
      count_in    = count_ff;
      rd_cnt_in   = rd_cnt_ff;
      rd_vld_in   = issue;
      sum_in      = sum_ff;
      sq_in       = sq_ff;
      mean_in     = mean_ff;
      dev_abs     = (rd_data >= mean_ff) ? rd_data - mean_ff : mean_ff - rd_data;
      prod_in     = swls_pkg::var_type'(dev_abs) * swls_pkg::var_type'(dev_abs);
      prod_vld_in = rd_vld_ff && (state_ff == swls_pkg::ST_DEV);

      if (req_fire) begin
         // Write the new sample, advance the slot, grow the count to the window, restart the read count and sum.
         slot_in   = (slot_ff == swls_pkg::addr_type'(swls_pkg::WINDOW - 1))
                     ? '0 : slot_ff + 1'b1;
         if (count_ff != swls_pkg::cnt_type'(swls_pkg::WINDOW)) begin
            count_in = count_ff + 1'b1;
         end
         rd_cnt_in = '0;
         sum_in    = '0;
      end
      if (issue) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
      end
      if (rd_vld_ff && (state_ff == swls_pkg::ST_SUM)) begin
         sum_in = sum_ff + swls_pkg::sum_type'(rd_data);
      end
      if ((state_ff == swls_pkg::ST_DIV_MEAN) && div_done) begin
         mean_in   = div_quotient[swls_pkg::DATA_W-1:0];
         rd_cnt_in = '0;
         sq_in     = '0;
      end
      if (prod_vld_ff) begin
         sq_in = sq_ff + swls_pkg::sq_type'(prod_ff);
      end
   end

   // Output register: hold until taken, load when free.
   always_comb begin
      out_vld_in   = out_vld_ff;
      out_mean_in  = out_mean_ff;
      out_stdev_in = out_stdev_ff;
      out_held_in  = out_held_ff;
      out_full_in  = out_full_ff;
      if (rsp_fire) begin
         out_vld_in = 1'b0;
      end
      if (load_out) begin
         out_vld_in   = 1'b1;
         out_mean_in  = mean_ff;
         out_stdev_in = stdev;
         out_held_in  = swls_pkg::held_type'(count_ff);
         out_full_in  = count_ff == swls_pkg::cnt_type'(swls_pkg::WINDOW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= swls_pkg::ST_IDLE;
         slot_ff     <= '0;
         count_ff    <= '0;
         rd_cnt_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         slot_ff     <= slot_in;
         count_ff    <= count_in;
         rd_cnt_ff   <= rd_cnt_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      sq_ff        <= sq_in;
      mean_ff      <= mean_in;
      prod_ff      <= prod_in;
      out_mean_ff  <= out_mean_in;
      out_stdev_ff <= out_stdev_in;
      out_held_ff  <= out_held_in;
      out_full_ff  <= out_full_in;
   end

   assign div_dividend = (state_ff == swls_pkg::ST_SUM) ? swls_pkg::sq_type'(sum_ff) : sq_ff;

   swls_ring u_ring (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (slot_ff),
      .wr_data (req_ch.latency_us),
      .rd_addr (rd_cnt_ff[swls_pkg::AW-1:0]),
      .rd_data (rd_data)
   );

   swls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   swls_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (div_quotient[swls_pkg::VAR_W-1:0]),
      .done  (sqrt_done),
      .root  (stdev)
   );

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.mean_us     = out_mean_ff;
   assign rsp_ch.stdev_us    = out_stdev_ff;
   assign rsp_ch.held_count  = out_held_ff;
   assign rsp_ch.window_full = out_full_ff;

   `SWLS_ASSERT_NEXT(a_accept_starts_sum, clock, reset, req_fire, state_ff == swls_pkg::ST_SUM)
   `SWLS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                    count_ff <= swls_pkg::cnt_type'(swls_pkg::WINDOW))
   `SWLS_ASSERT_NOW(a_reads_within_count, clock, reset, 1'b1, rd_cnt_ff <= count_ff)
   `SWLS_ASSERT_NOW(a_div_start_idle, clock, reset, div_start, !div_busy)

endmodule

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Traffic phases, told apart by their stimulus or idling pattern.
   typedef enum int {
      PH_DIRECTED,
      PH_STREAM,
      PH_SENDER_GAPS,
      PH_SINK_STALLS,
      PH_LIGHT_GAPS,
      PH_BACKLOG
   } phase_type;

   // Burst styles for the random samples.
   typedef enum int {
      STYLE_WIDE,
      STYLE_CLUSTER,
      STYLE_LOW,
      STYLE_EXTREME
   } burst_style_type;

   localparam swls_pkg::data_type LAT_MAX = {swls_pkg::DATA_W{1'b1}};

   // Receiver hold-off in the backlog phase, counted in cycles.
   localparam int unsigned BACKLOG_HOLD_CYCLES = 600;
   // Cycles to let pass after the last response, before the verdict.
   localparam int unsigned TAIL_CYCLES = 400;

   typedef struct packed {
      swls_pkg::data_type mean_us;
      swls_pkg::data_type stdev_us;
      swls_pkg::held_type held_count;
      logic               window_full;
   } window_stats_type;

   logic clock;
   logic reset;

   swls_req_if req_ch ();
   swls_rsp_if rsp_ch ();

   sliding_window_latency_stats_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Samples waiting to be offered, and statistics owed by the block, oldest first.
   swls_pkg::data_type latency_backlog [$];
   window_stats_type   stats_due [$];

   // Shadow of the block's window.
   bit [swls_pkg::DATA_W-1:0] shadow_ring [swls_pkg::WINDOW];
   int unsigned      shadow_slot  = 0;
   int unsigned      shadow_count = 0;

   // Knobs set per phase; the drivers read the rates and rsp_held at the falling edge.
   phase_type        phase          = PH_DIRECTED;
   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_stall_pct = 0;
   logic             rsp_held       = 1'b0;

   logic             req_taken      = 1'b0;
   int unsigned      error_count    = 0;

   // Clock, plus known values on every input from time zero.
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.latency_us = '0;
      rsp_ch.ready      = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit: several times the slowest legal run.
   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

   // Bitwise integer square root: build the root from the top bit down,
   // keep each bit whose square still fits under the value.
   function automatic swls_pkg::data_type floor_root(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return swls_pkg::data_type'(root);
   endfunction

   // Fold one sample into the shadow window and work out the statistics it yields:
   // integer mean first, then the mean square deviation about that mean, then its root.
   task automatic fold_in_sample(input swls_pkg::data_type sample,
                                 output window_stats_type stats);
      logic [63:0] total;
      logic [63:0] sq_total;
      logic [63:0] mean;
      logic [63:0] diff;
      total    = '0;
      sq_total = '0;
      shadow_ring[shadow_slot] = sample;
      shadow_slot = (shadow_slot + 1 == swls_pkg::WINDOW) ? 0 : shadow_slot + 1;
      if (shadow_count < swls_pkg::WINDOW) begin
         shadow_count++;
      end
      // Until the ring wraps the held samples sit in slots 0..count-1; afterwards all slots.
      for (int i = 0; i < shadow_count; i++) begin
         total += shadow_ring[i];
      end
      mean = total / shadow_count;
      for (int i = 0; i < shadow_count; i++) begin
         diff = (shadow_ring[i] >= mean) ? shadow_ring[i] - mean : mean - shadow_ring[i];
         sq_total += diff * diff;
      end
      stats.mean_us     = swls_pkg::data_type'(mean);
      stats.stdev_us    = floor_root(sq_total / shadow_count);
      stats.held_count  = swls_pkg::held_type'(shadow_count);
      stats.window_full = (shadow_count >= swls_pkg::WINDOW);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                  $time, name, want, want, got, got);
         error_count++;
      end
   endtask

   // Monitor: sample both channels at the rising edge. Retire a response beat
   // before folding in a request beat taken on the same edge; the block cannot
   // answer a sample on the edge that takes it.
   always @(posedge clock) begin : watch_beats
      window_stats_type got;
      window_stats_type want;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{mean_us:     rsp_ch.mean_us,
                 stdev_us:    rsp_ch.stdev_us,
                 held_count:  rsp_ch.held_count,
                 window_full: rsp_ch.window_full};
         if (stats_due.size() == 0) begin
            $display("%0t: response beat with nothing expected: mean %0d stdev %0d held %0d full %0b",
                     $time, got.mean_us, got.stdev_us, got.held_count, got.window_full);
            error_count++;
         end else begin
            want = stats_due[0];
            stats_due.delete(0);
            check_field("mean_us",     64'(want.mean_us),     64'(got.mean_us));
            check_field("stdev_us",    64'(want.stdev_us),    64'(got.stdev_us));
            check_field("held_count",  64'(want.held_count),  64'(got.held_count));
            check_field("window_full", 64'(want.window_full), 64'(got.window_full));
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         fold_in_sample(req_ch.latency_us, want);
         stats_due = {stats_due, want};
      end
   end

   // Sender: at the falling edge, once the current beat has gone (or none is up),
   // either offer the next sample or stay idle. Keep valid steady while
   // a beat waits for ready.
   always @(negedge clock) begin : drive_samples
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (latency_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid      <= 1'b1;
            req_ch.latency_us <= latency_backlog[0];
            latency_backlog.delete(0);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: drop ready at random, and throughout any long hold-off.
   always @(negedge clock) begin : drive_ready
      rsp_ch.ready <= !reset && !rsp_held && ($urandom_range(99) >= recv_stall_pct);
   end

   // Long hold-off, counted here in cycles: stall the result side while the sender
   // keeps offering, so the output register fills and the block stops taking samples.
   initial begin : backlog_hold
      int unsigned left;
      wait (phase == PH_BACKLOG);
      @(negedge clock);
      rsp_held <= 1'b1;
      left = BACKLOG_HOLD_CYCLES;
      while (left != 0) begin
         @(negedge clock);
         left--;
      end
      rsp_held <= 1'b0;
   end

   function automatic swls_pkg::data_type draw_latency(input burst_style_type style,
                                                       input swls_pkg::data_type base);
      logic [swls_pkg::DATA_W:0] sum;
      case (style)
         STYLE_WIDE: begin
            return swls_pkg::data_type'($urandom);
         end
         STYLE_CLUSTER: begin
            // Tight spread around a base: small deviations, carry near the top saturates.
            sum = {1'b0, base} + {1'b0, swls_pkg::data_type'($urandom_range(0, 63))};
            return sum[swls_pkg::DATA_W] ? LAT_MAX : sum[swls_pkg::DATA_W-1:0];
         end
         STYLE_LOW: begin
            return swls_pkg::data_type'($urandom_range(0, 4095));
         end
         default: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return LAT_MAX;
               2:       return LAT_MAX - swls_pkg::data_type'($urandom_range(0, 3));
               default: return swls_pkg::data_type'($urandom_range(0, 3));
            endcase
         end
      endcase
   endfunction

   // Queue a phase's worth of random samples in bursts of one style, then wait
   // until every sample is taken and every owed result has arrived.
   task automatic run_phase(input phase_type which, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned items);
      burst_style_type    style;
      swls_pkg::data_type base;
      int unsigned        burst_left;
      burst_left     = 0;
      style          = STYLE_WIDE;
      base           = '0;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      phase          = which;
      for (int i = 0; i < items; i++) begin
         if (burst_left == 0) begin
            style      = burst_style_type'($urandom_range(3));
            base       = swls_pkg::data_type'($urandom);
            burst_left = $urandom_range(4, 40);
         end
         latency_backlog = {latency_backlog, draw_latency(style, base)};
         burst_left--;
      end
      while (latency_backlog.size() != 0 || req_ch.valid) begin
         @(posedge clock);
      end
      while (stats_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a lone top value, then a window alternating between the extremes
      // (largest deviation), the full flag coming up, and the ring wrapping as top
      // values overwrite the oldest entries (deviation falling, mean rising).
      latency_backlog = {latency_backlog, LAT_MAX};
      latency_backlog = {latency_backlog, swls_pkg::data_type'('0)};
      for (int i = 0; i < 14; i++) begin
         latency_backlog = {latency_backlog,
                            ((i % 2 == 0) ? LAT_MAX : swls_pkg::data_type'('0))};
      end
      for (int i = 0; i < 8; i++) begin
         latency_backlog = {latency_backlog, LAT_MAX};
      end
      run_phase(PH_DIRECTED, 0, 0, 0);

      run_phase(PH_STREAM,      0,  0,  140);
      run_phase(PH_SENDER_GAPS, 52, 0,  140);
      run_phase(PH_SINK_STALLS, 0,  52, 140);
      run_phase(PH_LIGHT_GAPS,  9,  9,  140);
      run_phase(PH_BACKLOG,     0,  0,  140);

      // Let any stray beat show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
